[sv/sgm_pkg.sv]
// shared constants and command codes for the signed graph spin update engine
// no dependencies; imported by the top level and its checker
`default_nettype none

package sgm_pkg;

  // parameter defaults
  localparam int NODES_DEF         = 1024;
  localparam int MAX_DEGREE_DEF    = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int CMD_W      = 3;
  localparam int NODE_IN_W  = 10;
  localparam int TIDX_W     = 4;
  localparam int FRAC_IN_W  = 16;
  localparam int DE_OUT_W   = 6;

  // acceptance threshold table
  localparam int THRESH_ENTRIES = 8;
  localparam int THR_IW         = 3;

  // saturation limits of the reported energy change
  localparam int DE_MAX = 31;
  localparam int DE_MIN = -32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE   = 3'd0,
    CMD_SET_SPIN   = 3'd1,
    CMD_LOAD_THR   = 3'd2,
    CMD_UPDATE     = 3'd3,
    CMD_READ_SPIN  = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

[sv/sgm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies; used for the node word store and the neighbor store
`default_nettype none

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/signed_graph_metropolis_spin_update.sv]
// Metropolis spin-flip engine for an Ising model on a signed graph
// depends on sgm_pkg and sgm_ram (node word store and neighbor store)
//
// Usage: one command beat enters on in_valid/in_ready, one result beat leaves on
// out_valid/out_ready for every command. Commands: add a signed edge, set a spin,
// load a threshold entry, update one node, read a spin.
// After reset the block sweeps the node store, writing spin +1 and degree 0 to
// every node; in_ready stays low meanwhile.
// The neighbor store is never cleared: only slots below a node's degree are read.
// From the accepting edge to out_valid, set, load, read and an edge with a node out of
// range pass S_RD_A, S_DISP and S_RESP; an edge turned away for a full list also passes
// S_EB, an accepted edge S_EB and S_EW2, and an update S_LOOP and S_DECIDE, which an
// update of a node out of range skips.
// The update time is set by the neighbor walk: one neighbor slot read and one
// neighbor spin read per neighbor over the single read port of each store,
// overlapped so that one neighbor retires per cycle once the walk has filled.
// One command is worked on at a time; in_ready rises again once the result sits
// in the output register, so a stalled receiver holds at most one finished beat
// plus one command in flight, which waits for the output register to drain.
`default_nettype none

module signed_graph_metropolis_spin_update #(
  parameter int NODES         = sgm_pkg::NODES_DEF,
  parameter int MAX_DEGREE    = sgm_pkg::MAX_DEGREE_DEF,
  parameter int FRACTION_BITS = sgm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sgm_pkg::CMD_W-1:0]        command,
  input  wire logic [sgm_pkg::NODE_IN_W-1:0]    node_a,
  input  wire logic [sgm_pkg::NODE_IN_W-1:0]    node_b,
  input  wire logic                             edge_negative,
  input  wire logic                             spin_up,
  input  wire logic [sgm_pkg::TIDX_W-1:0]       table_index,
  input  wire logic [sgm_pkg::FRAC_IN_W-1:0]    threshold_value,
  input  wire logic [sgm_pkg::FRAC_IN_W-1:0]    random_u,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  status,
  output logic                                  spin_now,
  output logic                                  flipped,
  output logic signed [sgm_pkg::DE_OUT_W-1:0]   energy_change
);

  import sgm_pkg::*;

  localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int NB_DEPTH = NODES * (2 ** SLOT_W);
  localparam int NB_AW    = NODE_AW + SLOT_W;
  localparam int NODE_WW  = 1 + DEG_W;
  localparam int NB_WW    = NODE_AW + 1;
  localparam int ACC_W    = $clog2(MAX_DEGREE + 1) + 1;
  localparam int DE_W     = ACC_W + 1;
  localparam int FRAC_W   = FRACTION_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_DISP, S_EB, S_EW2, S_LOOP, S_DECIDE, S_RESP
  } state_t;

  state_t               state;
  logic [NODE_AW-1:0]   clr_addr;

  // captured command
  cmd_t                 cmd_r;
  logic [NODE_AW-1:0]   a_r;
  logic [NODE_AW-1:0]   b_r;
  logic                 a_ok;
  logic                 b_ok;
  logic                 same_ab;
  logic                 neg_r;
  logic                 up_r;
  logic [TIDX_W-1:0]    tidx_r;
  logic [FRAC_W-1:0]    tval_r;
  logic [FRAC_W-1:0]    ru_r;

  // node words read back
  logic                 si_r;
  logic [DEG_W-1:0]     deg_a;
  logic                 sb_r;
  logic [DEG_W-1:0]     deg_b;

  // neighbor walk
  logic [DEG_W-1:0]     iss;
  logic                 p1;
  logic                 p2;
  logic                 neg1;
  logic signed [ACC_W-1:0] acc;

  // finished result waiting for the output register
  logic                 res_status;
  logic                 res_spin;
  logic                 res_flip;
  logic signed [DE_OUT_W-1:0] res_de;

  // threshold table
  logic [FRAC_W-1:0]    thr [THRESH_ENTRIES];

  // memory ports
  logic                 node_we;
  logic [NODE_AW-1:0]   node_waddr;
  logic [NODE_WW-1:0]   node_wdata;
  logic [NODE_AW-1:0]   node_raddr;
  logic [NODE_WW-1:0]   node_rdata;
  logic                 nb_we;
  logic [NB_AW-1:0]     nb_waddr;
  logic [NB_WW-1:0]     nb_wdata;
  logic [NB_AW-1:0]     nb_raddr;
  logic [NB_WW-1:0]     nb_rdata;

  logic                 issue;
  logic                 edge_reject;
  logic                 accept_flip;
  logic signed [ACC_W-1:0]    acc_m1;
  logic [THR_IW-1:0]          thr_idx;
  logic signed [DE_W-1:0]     de_full;
  logic signed [DE_OUT_W-1:0] de_sat;
  logic                 tidx_ok;
  logic                 r_spin;
  logic                 r_neg;

  assign in_ready = (state == S_IDLE);

  sgm_ram #(.WIDTH(NODE_WW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  sgm_ram #(.WIDTH(NB_WW), .DEPTH(NB_DEPTH)) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (nb_wdata),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  // neighbor walk issue and edge capacity check
  assign issue   = (state == S_LOOP) && (iss < deg_a);
  assign tidx_ok = (tidx_r >= TIDX_W'(1)) && (tidx_r <= TIDX_W'(THRESH_ENTRIES));
  assign r_spin  = node_rdata[DEG_W];
  assign r_neg   = nb_rdata[0];

  always_comb begin
    if (same_ab) begin
      edge_reject = ((DEG_W+1)'(deg_a) + (DEG_W+1)'(2)) > (DEG_W+1)'(MAX_DEGREE);
    end else begin
      edge_reject = ((DEG_W+1)'(deg_a) >= (DEG_W+1)'(MAX_DEGREE)) ||
                    ((DEG_W+1)'(node_rdata[DEG_W-1:0]) >= (DEG_W+1)'(MAX_DEGREE));
    end
  end

  // acceptance test and saturated energy change
  assign acc_m1  = acc - ACC_W'(1);
  assign thr_idx = THR_IW'(acc_m1);
  assign de_full = {acc, 1'b0};

  always_comb begin
    if (acc <= 0) begin
      accept_flip = 1'b1;
    end else begin
      accept_flip = (acc <= THRESH_ENTRIES) && (ru_r < thr[thr_idx]);
    end
    if (de_full > DE_MAX) begin
      de_sat = DE_OUT_W'(DE_MAX);
    end else if (de_full < DE_MIN) begin
      de_sat = DE_OUT_W'(DE_MIN);
    end else begin
      de_sat = DE_OUT_W'(de_full);
    end
  end

  // read address selection
  always_comb begin
    nb_raddr = {a_r, iss[SLOT_W-1:0]};
    if (state == S_LOOP) begin
      node_raddr = nb_rdata[NB_WW-1:1];
    end else if (state == S_DISP) begin
      node_raddr = b_r;
    end else begin
      node_raddr = a_r;
    end
  end

  // write port selection
  always_comb begin
    node_we    = 1'b0;
    node_waddr = a_r;
    node_wdata = {si_r, deg_a};
    nb_we      = 1'b0;
    nb_waddr   = {a_r, deg_a[SLOT_W-1:0]};
    nb_wdata   = {b_r, neg_r};
    unique case (state)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_addr;
        node_wdata = {1'b1, DEG_W'(0)};
      end
      S_DISP: begin
        if (cmd_r == CMD_SET_SPIN && a_ok) begin
          node_we    = 1'b1;
          node_wdata = {up_r, node_rdata[DEG_W-1:0]};
        end
      end
      S_EB: begin
        if (!edge_reject) begin
          nb_we   = 1'b1;
          node_we = 1'b1;
          if (same_ab) begin
            node_wdata = {si_r, deg_a + DEG_W'(2)};
          end else begin
            node_wdata = {si_r, deg_a + DEG_W'(1)};
          end
        end
      end
      S_EW2: begin
        nb_we    = 1'b1;
        nb_wdata = {a_r, neg_r};
        if (same_ab) begin
          nb_waddr = {a_r, SLOT_W'(deg_a + DEG_W'(1))};
        end else begin
          nb_waddr   = {b_r, deg_b[SLOT_W-1:0]};
          node_we    = 1'b1;
          node_waddr = b_r;
          node_wdata = {sb_r, deg_b + DEG_W'(1)};
        end
      end
      S_DECIDE: begin
        node_we    = accept_flip;
        node_wdata = {~si_r, deg_a};
      end
      default: begin
      end
    endcase
  end

  // threshold table load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THRESH_ENTRIES; i++) begin
        thr[i] <= '0;
      end
    end else if (state == S_DISP && cmd_r == CMD_LOAD_THR && tidx_ok) begin
      thr[THR_IW'(tidx_r - TIDX_W'(1))] <= tval_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
    end else begin
      // a taken beat empties the register unless a new one loads below
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // clearing sweep of the node store
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_AW'(1);
          if (clr_addr == NODE_AW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        // capture the command beat
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(command);
            a_r     <= NODE_AW'(node_a);
            b_r     <= NODE_AW'(node_b);
            a_ok    <= 32'(node_a) < NODES;
            b_ok    <= 32'(node_b) < NODES;
            same_ab <= (node_a == node_b);
            neg_r   <= edge_negative;
            up_r    <= spin_up;
            tidx_r  <= table_index;
            tval_r  <= FRAC_W'(threshold_value);
            ru_r    <= FRAC_W'(random_u);
            state   <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_DISP;
        end
        // node a word is back: dispatch on the command
        S_DISP: begin
          si_r     <= r_spin;
          deg_a    <= node_rdata[DEG_W-1:0];
          res_flip <= 1'b0;
          res_de   <= '0;
          unique case (cmd_r)
            CMD_ADD_EDGE: begin
              res_status <= !(a_ok && b_ok);
              res_spin   <= a_ok & r_spin;
              state      <= (a_ok && b_ok) ? S_EB : S_RESP;
            end
            CMD_SET_SPIN: begin
              res_status <= 1'b0;
              res_spin   <= a_ok & up_r;
              state      <= S_RESP;
            end
            CMD_UPDATE: begin
              res_status <= 1'b0;
              res_spin   <= a_ok & r_spin;
              iss        <= '0;
              p1         <= 1'b0;
              p2         <= 1'b0;
              acc        <= '0;
              state      <= a_ok ? S_LOOP : S_RESP;
            end
            default: begin
              res_status <= 1'b0;
              res_spin   <= a_ok & r_spin;
              state      <= S_RESP;
            end
          endcase
        end
        // node b word is back: check room, first list write happens here
        S_EB: begin
          sb_r  <= r_spin;
          deg_b <= node_rdata[DEG_W-1:0];
          if (edge_reject) begin
            res_status <= 1'b1;
            state      <= S_RESP;
          end else begin
            state <= S_EW2;
          end
        end
        S_EW2: begin
          state <= S_RESP;
        end
        // neighbor walk: slot read, then neighbor spin read, then accumulate
        S_LOOP: begin
          if (issue) begin
            iss <= iss + DEG_W'(1);
          end
          p1 <= issue;
          p2 <= p1;
          if (p1) begin
            neg1 <= r_neg;
          end
          if (p2) begin
            if (si_r ^ r_spin ^ neg1) begin
              acc <= acc - ACC_W'(1);
            end else begin
              acc <= acc + ACC_W'(1);
            end
          end
          if (!issue && !p1 && !p2) begin
            state <= S_DECIDE;
          end
        end
        // flip decision, spin write back
        S_DECIDE: begin
          res_flip <= accept_flip;
          res_spin <= si_r ^ accept_flip;
          res_de   <= de_sat;
          state    <= S_RESP;
        end
        // hand the result to the output register
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            spin_now      <= res_spin;
            flipped       <= res_flip;
            energy_change <= res_de;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/sgm_checker.sv]
// port level checks for the signed graph spin update engine, bound to the top level
// depends on sgm_pkg and signed_graph_metropolis_spin_update
`default_nettype none

module sgm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [sgm_pkg::CMD_W-1:0]        command,
  input wire logic [sgm_pkg::NODE_IN_W-1:0]    node_a,
  input wire logic [sgm_pkg::NODE_IN_W-1:0]    node_b,
  input wire logic                             edge_negative,
  input wire logic                             spin_up,
  input wire logic [sgm_pkg::TIDX_W-1:0]       table_index,
  input wire logic [sgm_pkg::FRAC_IN_W-1:0]    threshold_value,
  input wire logic [sgm_pkg::FRAC_IN_W-1:0]    random_u,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             status,
  input wire logic                             spin_now,
  input wire logic                             flipped,
  input wire logic signed [sgm_pkg::DE_OUT_W-1:0] energy_change
);

  import sgm_pkg::*;

  // a stalled result beat holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(spin_now) &&
      $stable(flipped) && $stable(energy_change))
    else $error("result beat changed while stalled");

  // the clearing sweep keeps the command channel closed right after reset
  a_clear_closed: assert property (@(posedge clk) $fell(rst) |-> !in_ready)
    else $error("command accepted during node store clearing");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command accepted while one is in flight");

  // a negative energy change always flips
  a_neg_flips: assert property (@(posedge clk) disable iff (rst)
    out_valid && energy_change[DE_OUT_W-1] |-> flipped)
    else $error("negative energy change without a flip");

  // a rejected edge reports no update fields
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !flipped && energy_change == '0)
    else $error("rejected edge carries update fields");

endmodule

bind signed_graph_metropolis_spin_update sgm_checker u_sgm_checker (.*);

`default_nettype wire

[tb/sgm_checker.sv]
// checker for the signed graph spin update engine: watches both channels,
// predicts each result beat and compares it field by field; depends on sgm_pkg
`default_nettype none

module sgm_scoreboard (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [sgm_pkg::CMD_W-1:0]      command,
  input  wire logic [sgm_pkg::NODE_IN_W-1:0]  node_a,
  input  wire logic [sgm_pkg::NODE_IN_W-1:0]  node_b,
  input  wire logic                           edge_negative,
  input  wire logic                           spin_up,
  input  wire logic [sgm_pkg::TIDX_W-1:0]     table_index,
  input  wire logic [sgm_pkg::FRAC_IN_W-1:0]  threshold_value,
  input  wire logic [sgm_pkg::FRAC_IN_W-1:0]  random_u,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           status,
  input  wire logic                           spin_now,
  input  wire logic                           flipped,
  input  wire logic signed [sgm_pkg::DE_OUT_W-1:0] energy_change,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  beats_checked,
  output int                                  flips_seen,
  output int                                  edges_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int NODE_COUNT = NODES_DEF;
  localparam int DEG_MAX    = MAX_DEGREE_DEF;
  localparam int PRINT_MAX  = 40;

  typedef struct packed {
    logic                status;
    logic                spin_now;
    logic                flipped;
    logic [DE_OUT_W-1:0] energy_bits;
  } beat_result_t;

  // shadow copy of the graph, spins and acceptance thresholds
  logic                 spin_state   [NODE_COUNT];
  int                   degree       [NODE_COUNT];
  logic [NODE_IN_W-1:0] nb_peer      [NODE_COUNT][DEG_MAX];
  logic                 nb_sign      [NODE_COUNT][DEG_MAX];
  logic [FRAC_IN_W-1:0] accept_level [THRESH_ENTRIES];

  beat_result_t results_due [$];

  task automatic report(input string what, input int got, input int want);
    if (mismatches < PRINT_MAX) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // one command applied to the shadow state, returning the result it must produce
  function automatic beat_result_t metropolis_step(
    input logic [CMD_W-1:0]     code,
    input logic [NODE_IN_W-1:0] a,
    input logic [NODE_IN_W-1:0] b,
    input logic                 neg,
    input logic                 up,
    input logic [TIDX_W-1:0]    idx,
    input logic [FRAC_IN_W-1:0] level,
    input logic [FRAC_IN_W-1:0] draw
  );
    beat_result_t r;
    int           de;
    int           half;
    logic         si;
    logic         sj;
    logic         accept;
    r  = '0;
    de = 0;
    case (code)
      CMD_ADD_EDGE: begin
        // both lists need room; a self loop takes two slots of one list
        if (a >= NODE_COUNT || b >= NODE_COUNT) r.status = 1'b1;
        else if (a == b) r.status = (degree[a] + 2 > DEG_MAX);
        else r.status = (degree[a] >= DEG_MAX || degree[b] >= DEG_MAX);
        if (r.status) begin
          edges_rejected++;
        end else begin
          nb_peer[a][degree[a]] = b;
          nb_sign[a][degree[a]] = neg;
          degree[a]++;
          nb_peer[b][degree[b]] = a;
          nb_sign[b][degree[b]] = neg;
          degree[b]++;
        end
      end
      CMD_SET_SPIN: begin
        if (a < NODE_COUNT) spin_state[a] = up;
      end
      CMD_LOAD_THR: begin
        // indexes outside 1..8 are dropped
        if (idx >= 1 && idx <= THRESH_ENTRIES) accept_level[idx - 1] = level;
      end
      CMD_UPDATE: begin
        if (a < NODE_COUNT) begin
          si = spin_state[a];
          // coupling term is negative when an odd count of factors is -1
          for (int k = 0; k < degree[a] && k < DEG_MAX; k++) begin
            sj = (nb_peer[a][k] < NODE_COUNT) ? spin_state[nb_peer[a][k]] : 1'b1;
            if (~si ^ ~sj ^ nb_sign[a][k]) de -= 2;
            else de += 2;
          end
          // downhill always flips, uphill needs the draw below the threshold
          if (de <= 0) begin
            accept = 1'b1;
          end else begin
            half   = de / 2;
            accept = 1'b0;
            if (half <= THRESH_ENTRIES) accept = (draw < accept_level[half - 1]);
          end
          if (accept) begin
            spin_state[a] = ~si;
            r.flipped     = 1'b1;
            flips_seen++;
          end
        end
      end
      default: ;  // unknown codes behave as a read
    endcase
    if (de > DE_MAX) de = DE_MAX;
    if (de < DE_MIN) de = DE_MIN;
    r.energy_bits = de[DE_OUT_W-1:0];
    r.spin_now    = (a < NODE_COUNT) ? spin_state[a] : 1'b0;
    return r;
  endfunction

  // result side first: a result beat always belongs to an earlier command
  always @(posedge clk) begin : watch
    beat_result_t want;
    if (rst) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        spin_state[n] = 1'b1;
        degree[n]     = 0;
      end
      for (int k = 0; k < THRESH_ENTRIES; k++) accept_level[k] = '0;
      results_due.delete();
      mismatches     = 0;
      beats_checked  = 0;
      flips_seen     = 0;
      edges_rejected = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (results_due.size() == 0) begin
          report("result beat with nothing pending", 1, 0);
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) report("status", status, want.status);
          if (spin_now !== want.spin_now) report("spin_now", spin_now, want.spin_now);
          if (flipped !== want.flipped) report("flipped", flipped, want.flipped);
          if (energy_change !== $signed(want.energy_bits)) begin
            report("energy_change", int'(energy_change), int'($signed(want.energy_bits)));
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.insert(results_due.size(),
                           metropolis_step(command, node_a, node_b, edge_negative,
                                           spin_up, table_index, threshold_value,
                                           random_u));
      end
    end
    pending <= results_due.size();
  end

endmodule

`default_nettype wire

[tb/signed_graph_metropolis_spin_update_tb.sv]
// testbench top for the signed graph spin update engine: clock, reset, command
// and result traffic, verdict; depends on sgm_pkg, sgm_scoreboard and the block itself
`default_nettype none

module signed_graph_metropolis_spin_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 128;

  // codes past the defined commands
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  logic                  clk;
  logic                  rst             = 1'b1;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command         = '0;
  logic [NODE_IN_W-1:0]  node_a          = '0;
  logic [NODE_IN_W-1:0]  node_b          = '0;
  logic                  edge_negative   = 1'b0;
  logic                  spin_up         = 1'b0;
  logic [TIDX_W-1:0]     table_index     = '0;
  logic [FRAC_IN_W-1:0]  threshold_value = '0;
  logic [FRAC_IN_W-1:0]  random_u        = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic                  status;
  logic                  spin_now;
  logic                  flipped;
  logic signed [DE_OUT_W-1:0] energy_change;

  int mismatches;
  int pending;
  int beats_checked;
  int flips_seen;
  int edges_rejected;
  int commands_sent = 0;

  logic tx_calm     = 1'b0;
  logic rx_calm     = 1'b0;
  logic hold_output = 1'b0;

  signed_graph_metropolis_spin_update DUT (
    .clk, .rst, .in_valid, .in_ready, .command, .node_a, .node_b, .edge_negative,
    .spin_up, .table_index, .threshold_value, .random_u, .out_valid, .out_ready,
    .status, .spin_now, .flipped, .energy_change
  );

  sgm_scoreboard spin_checker (
    .clk, .rst, .in_valid, .in_ready, .command, .node_a, .node_b, .edge_negative,
    .spin_up, .table_index, .threshold_value, .random_u, .out_valid, .out_ready,
    .status, .spin_now, .flipped, .energy_change, .mismatches, .pending,
    .beats_checked, .flips_seen, .edges_rejected
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one command beat: random gap, then hold valid until accepted
  task automatic send_cmd(
    input logic [CMD_W-1:0]     code,
    input logic [NODE_IN_W-1:0] a,
    input logic [NODE_IN_W-1:0] b,
    input logic                 neg,
    input logic                 up,
    input logic [TIDX_W-1:0]    idx,
    input logic [FRAC_IN_W-1:0] level,
    input logic [FRAC_IN_W-1:0] draw
  );
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= code;
    node_a          <= a;
    node_b          <= b;
    edge_negative   <= neg;
    spin_up         <= up;
    table_index     <= idx;
    threshold_value <= level;
    random_u        <= draw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  // fractions lean on the extremes
  function automatic logic [FRAC_IN_W-1:0] pick_fraction();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return FRAC_IN_W'($urandom_range(0, 65535));
  endfunction

  // command stream
  initial begin : stimulus
    logic [CMD_W-1:0]     code;
    logic [NODE_IN_W-1:0] a;
    logic [NODE_IN_W-1:0] b;
    logic [TIDX_W-1:0]    idx;
    int                   base;
    int                   span;
    int                   roll;
    int                   link_share;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: reset spins, isolated node, table loads, full lists, self loops
    send_cmd(CMD_READ_SPIN, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_UPDATE, 1023, 0, 0, 0, 0, 0, 16'hffff);
    send_cmd(CMD_READ_SPIN, 1023, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_SET_SPIN, 5, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_SET_SPIN, 1023, 1023, 1, 1, 15, 16'hffff, 16'hffff);
    send_cmd(CMD_LOAD_THR, 0, 0, 0, 0, 1, 16'hffff, 0);
    send_cmd(CMD_LOAD_THR, 0, 0, 0, 0, TIDX_W'(THRESH_ENTRIES), 16'hffff, 0);
    send_cmd(CMD_LOAD_THR, 0, 0, 0, 0, 0, 16'h1234, 0);
    send_cmd(CMD_LOAD_THR, 0, 0, 0, 0, 15, 16'habcd, 0);
    send_cmd(CMD_ADD_EDGE, 0, 1, 0, 0, 0, 0, 0);
    send_cmd(CMD_ADD_EDGE, 0, 1, 1, 0, 0, 0, 0);
    send_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_ADD_EDGE, 2, 2, 0, 0, 0, 0, 0);
    send_cmd(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 0);
    repeat (4) send_cmd(CMD_ADD_EDGE, 3, 3, 0, 0, 0, 0, 0);
    send_cmd(CMD_ADD_EDGE, 3, 4, 0, 0, 0, 0, 0);
    send_cmd(CMD_ADD_EDGE, 3, 3, 1, 0, 0, 0, 0);
    send_cmd(CMD_UPDATE, 3, 0, 0, 0, 0, 0, 16'hffff);
    send_cmd(CMD_UPDATE, 3, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_ADD_EDGE, 6, 7, 0, 0, 0, 0, 0);
    send_cmd(CMD_SET_SPIN, 7, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_UPDATE, 6, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_UNKNOWN_HI, 3, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_UNKNOWN_LO, 1023, 0, 0, 0, 0, 0, 0);

    // random: each phase builds a small cluster of nodes, then mostly updates it
    for (int p = 0; p < PHASES; p++) begin
      span    = $urandom_range(4, 24);
      base    = (p == PHASES - 1) ? NODES_DEF - span : $urandom_range(0, NODES_DEF - span);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (p == PHASES / 2) hold_output = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll       = $urandom_range(0, 99);
        link_share = (n < 40) ? 50 : 8;
        a          = NODE_IN_W'(base + $urandom_range(0, span - 1));
        b          = NODE_IN_W'($urandom_range(0, NODES_DEF - 1));
        if ($urandom_range(0, 9) == 0) a = NODE_IN_W'($urandom_range(0, NODES_DEF - 1));
        if (roll < link_share) begin
          code = CMD_ADD_EDGE;
          roll = $urandom_range(0, 19);
          if (roll < 2) b = a;
          else if (roll < 19) b = NODE_IN_W'(base + $urandom_range(0, span - 1));
        end else if (roll < link_share + 12) begin
          code = CMD_SET_SPIN;
        end else if (roll < link_share + 19) begin
          code = CMD_LOAD_THR;
        end else if (roll < 93) begin
          code = CMD_UPDATE;
        end else if (roll < 97) begin
          code = CMD_READ_SPIN;
        end else begin
          code = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        end
        if ($urandom_range(0, 6) == 0) idx = TIDX_W'($urandom_range(0, 15));
        else idx = TIDX_W'($urandom_range(1, THRESH_ENTRIES));
        send_cmd(code, a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), idx,
                 pick_fraction(), pick_fraction());
      end
    end
    in_valid <= 1'b0;

    // drain, then let the last command settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d commands, %0d result beats checked, %0d mismatches",
             commands_sent, beats_checked, mismatches);
    $display("summary: %0d spin flips, %0d edges turned away", flips_seen, edges_rejected);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random ready gaps, calm stretches, one long hold-off
  initial begin : receiver
    int hold;
    int beats;
    bit held;
    beats = 0;
    held  = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (beats % 100 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_output && !held) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  // watchdog on cycles with no beat moving on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
